// ===== sv/ray_box_slab_test_top_defines.svh =====
// Assertion macros for the ray box slab test block.
// RBST_ASSERT_NOW checks a consequence in the same cycle,
// RBST_ASSERT_NEXT in the cycle after.
`ifndef RAY_BOX_SLAB_TEST_TOP_DEFINES_SVH
`define RAY_BOX_SLAB_TEST_TOP_DEFINES_SVH

`ifndef SYNTH
`define RBST_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rbst: same-cycle check failed");
`define RBST_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rbst: next-cycle check failed");
`else
`define RBST_ASSERT_NOW(label, ante, cons)
`define RBST_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== sv/rbst_pkg.sv =====
`default_nettype none

package rbst_pkg;

   localparam int COORD_BITS   = 32;
   localparam int FRAC_BITS    = 16;
   localparam int NUM_AXES     = 3;
   localparam int NUM_REGS     = 6;
   localparam int REG_IDX_BITS = $clog2(NUM_REGS);
   // register stages ahead of the result register
   localparam int PIPE_STAGES  = 6;

   localparam int PROD_W = 2 * COORD_BITS;
   localparam int Q_W    = PROD_W - FRAC_BITS;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [COORD_BITS:0]   diff_type;
   typedef logic [COORD_BITS-1:0]        mag_type;
   typedef logic [PROD_W-1:0]            prod_type;

   typedef struct packed {
      coord_type range_low;
      coord_type range_high;
   } range_type;

   localparam logic [REG_IDX_BITS-1:0] REG_BOX_MIN_X = REG_IDX_BITS'(0);
   localparam logic [REG_IDX_BITS-1:0] REG_BOX_MIN_Y = REG_IDX_BITS'(1);
   localparam logic [REG_IDX_BITS-1:0] REG_BOX_MIN_Z = REG_IDX_BITS'(2);
   localparam logic [REG_IDX_BITS-1:0] REG_BOX_MAX_X = REG_IDX_BITS'(3);
   localparam logic [REG_IDX_BITS-1:0] REG_BOX_MAX_Y = REG_IDX_BITS'(4);
   localparam logic [REG_IDX_BITS-1:0] REG_BOX_MAX_Z = REG_IDX_BITS'(5);

   localparam logic [Q_W-1:0] Q_NEG_LIMIT = Q_W'(1) << (COORD_BITS - 1);
   localparam logic [Q_W-1:0] Q_POS_LIMIT = Q_NEG_LIMIT - Q_W'(1);

   // magnitude product scaled by 2^-FRAC_BITS (truncated), sign applied, saturated
   function automatic coord_type sat_scale(input prod_type prod, input logic neg);
      logic [Q_W-1:0] q;
      coord_type      r;
      q = prod[PROD_W-1:FRAC_BITS];
      if (neg) begin
         if (q > Q_NEG_LIMIT) begin
            r = coord_type'(Q_NEG_LIMIT[COORD_BITS-1:0]);
         end else begin
            r = coord_type'(mag_type'(0) - q[COORD_BITS-1:0]);
         end
      end else begin
         if (q > Q_POS_LIMIT) begin
            r = coord_type'(Q_POS_LIMIT[COORD_BITS-1:0]);
         end else begin
            r = coord_type'(q[COORD_BITS-1:0]);
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== sv/ray_box_slab_test_top.sv =====
// Ray versus box slab test, fully pipelined, one ray accepted per cycle.
// A result strobes on rsp_valid once the ray has passed every pipeline stage and the result register.
// Throughput: 1 ray per cycle; busy is always low, six 32x32 multipliers in parallel.
// Results cannot be held off: each stays on the rsp_ ports for one cycle only.
// Reset (synchronous, active high) clears the box corners to 0 and drops
// every in-flight transaction.
`default_nettype none
`include "ray_box_slab_test_top_defines.svh"

module ray_box_slab_test_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire rbst_pkg::coord_type                 req_origin_x,
   input  wire rbst_pkg::coord_type                 req_origin_y,
   input  wire rbst_pkg::coord_type                 req_origin_z,
   input  wire rbst_pkg::coord_type                 req_recip_dir_x,
   input  wire rbst_pkg::coord_type                 req_recip_dir_y,
   input  wire rbst_pkg::coord_type                 req_recip_dir_z,
   input  wire logic                                req_neg_x,
   input  wire logic                                req_neg_y,
   input  wire logic                                req_neg_z,
   input  wire rbst_pkg::coord_type                 req_range_low,
   input  wire rbst_pkg::coord_type                 req_range_high,
   output logic                                     rsp_valid,
   output logic                                     rsp_hit,
   output logic                                     rsp_span_valid,
   output rbst_pkg::coord_type                      rsp_entry_distance,
   output rbst_pkg::coord_type                      rsp_exit_distance,
   input  wire logic                                csr_we,
   input  wire logic [rbst_pkg::REG_IDX_BITS-1:0]   csr_index,
   input  wire rbst_pkg::coord_type                 csr_wdata
);

   logic accept;

   rbst_pkg::coord_type box_min_ff [rbst_pkg::NUM_AXES];
   rbst_pkg::coord_type box_max_ff [rbst_pkg::NUM_AXES];
   rbst_pkg::coord_type box_min_in [rbst_pkg::NUM_AXES];
   rbst_pkg::coord_type box_max_in [rbst_pkg::NUM_AXES];

   rbst_pkg::coord_type org  [rbst_pkg::NUM_AXES];
   rbst_pkg::coord_type rcp  [rbst_pkg::NUM_AXES];
   logic                neg  [rbst_pkg::NUM_AXES];

   logic [rbst_pkg::PIPE_STAGES-1:0] valid_ff;
   rbst_pkg::range_type              range_ff [rbst_pkg::PIPE_STAGES];

   // stage 1: corner minus origin
   rbst_pkg::diff_type  near_diff_ff [rbst_pkg::NUM_AXES];
   rbst_pkg::diff_type  far_diff_ff  [rbst_pkg::NUM_AXES];
   rbst_pkg::coord_type rcp_ff       [rbst_pkg::NUM_AXES];
   rbst_pkg::diff_type  near_diff_in [rbst_pkg::NUM_AXES];
   rbst_pkg::diff_type  far_diff_in  [rbst_pkg::NUM_AXES];

   // stage 2: magnitudes and product signs
   rbst_pkg::mag_type near_mag_ff [rbst_pkg::NUM_AXES];
   rbst_pkg::mag_type far_mag_ff  [rbst_pkg::NUM_AXES];
   rbst_pkg::mag_type rcp_mag_ff  [rbst_pkg::NUM_AXES];
   logic              near_neg_ff [rbst_pkg::NUM_AXES];
   logic              far_neg_ff  [rbst_pkg::NUM_AXES];
   rbst_pkg::mag_type near_mag_in [rbst_pkg::NUM_AXES];
   rbst_pkg::mag_type far_mag_in  [rbst_pkg::NUM_AXES];
   rbst_pkg::mag_type rcp_mag_in  [rbst_pkg::NUM_AXES];
   logic              near_neg_in [rbst_pkg::NUM_AXES];
   logic              far_neg_in  [rbst_pkg::NUM_AXES];

   // stage 3: products
   rbst_pkg::prod_type near_prod_ff [rbst_pkg::NUM_AXES];
   rbst_pkg::prod_type far_prod_ff  [rbst_pkg::NUM_AXES];
   logic               near_sgn_ff  [rbst_pkg::NUM_AXES];
   logic               far_sgn_ff   [rbst_pkg::NUM_AXES];

   // stage 4: saturated slab distances
   rbst_pkg::coord_type near_dist_ff [rbst_pkg::NUM_AXES];
   rbst_pkg::coord_type far_dist_ff  [rbst_pkg::NUM_AXES];

   // stage 5: x and y merged
   rbst_pkg::coord_type tmin5_ff, tmax5_ff, tmin5_in, tmax5_in;
   rbst_pkg::coord_type near_z5_ff, far_z5_ff;
   logic                rej5_ff, rej5_in;

   // stage 6: z merged
   rbst_pkg::coord_type tmin6_ff, tmax6_ff, tmin6_in, tmax6_in;
   logic                rej6_ff, rej6_in;

   // result register
   logic                rsp_valid_ff;
   logic                rsp_hit_ff, rsp_hit_in;
   logic                rsp_span_valid_ff, rsp_span_valid_in;
   rbst_pkg::coord_type rsp_entry_ff, rsp_entry_in;
   rbst_pkg::coord_type rsp_exit_ff, rsp_exit_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign org[0] = req_origin_x;
   assign org[1] = req_origin_y;
   assign org[2] = req_origin_z;
   assign rcp[0] = req_recip_dir_x;
   assign rcp[1] = req_recip_dir_y;
   assign rcp[2] = req_recip_dir_z;
   assign neg[0] = req_neg_x;
   assign neg[1] = req_neg_y;
   assign neg[2] = req_neg_z;

   // configuration decode
   always_comb begin
      for (int i = 0; i < rbst_pkg::NUM_AXES; i++) begin
         box_min_in[i] = box_min_ff[i];
         box_max_in[i] = box_max_ff[i];
      end
      if (csr_we) begin
         unique case (csr_index)
            rbst_pkg::REG_BOX_MIN_X: box_min_in[0] = csr_wdata;
            rbst_pkg::REG_BOX_MIN_Y: box_min_in[1] = csr_wdata;
            rbst_pkg::REG_BOX_MIN_Z: box_min_in[2] = csr_wdata;
            rbst_pkg::REG_BOX_MAX_X: box_max_in[0] = csr_wdata;
            rbst_pkg::REG_BOX_MAX_Y: box_max_in[1] = csr_wdata;
            rbst_pkg::REG_BOX_MAX_Z: box_max_in[2] = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rbst_pkg::NUM_AXES; i++) begin
            box_min_ff[i] <= '0;
            box_max_ff[i] <= '0;
         end
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < rbst_pkg::NUM_AXES; i++) begin
            box_min_ff[i] <= box_min_in[i];
            box_max_ff[i] <= box_max_in[i];
         end
         valid_ff     <= {valid_ff[rbst_pkg::PIPE_STAGES-2:0], accept};
         rsp_valid_ff <= valid_ff[rbst_pkg::PIPE_STAGES-1];
      end
   end

   // per-axis datapath lanes
   always_comb begin
      for (int i = 0; i < rbst_pkg::NUM_AXES; i++) begin
         // sign bit picks which corner is the near plane
         near_diff_in[i] = rbst_pkg::diff_type'(neg[i] ? box_max_ff[i] : box_min_ff[i])
                         - rbst_pkg::diff_type'(org[i]);
         far_diff_in[i]  = rbst_pkg::diff_type'(neg[i] ? box_min_ff[i] : box_max_ff[i])
                         - rbst_pkg::diff_type'(org[i]);

         near_mag_in[i] = near_diff_ff[i][rbst_pkg::COORD_BITS]
                        ? rbst_pkg::mag_type'(-near_diff_ff[i])
                        : rbst_pkg::mag_type'(near_diff_ff[i]);
         far_mag_in[i]  = far_diff_ff[i][rbst_pkg::COORD_BITS]
                        ? rbst_pkg::mag_type'(-far_diff_ff[i])
                        : rbst_pkg::mag_type'(far_diff_ff[i]);
         rcp_mag_in[i]  = rcp_ff[i][rbst_pkg::COORD_BITS-1]
                        ? rbst_pkg::mag_type'(-rcp_ff[i])
                        : rbst_pkg::mag_type'(rcp_ff[i]);
         near_neg_in[i] = near_diff_ff[i][rbst_pkg::COORD_BITS]
                        ^ rcp_ff[i][rbst_pkg::COORD_BITS-1];
         far_neg_in[i]  = far_diff_ff[i][rbst_pkg::COORD_BITS]
                        ^ rcp_ff[i][rbst_pkg::COORD_BITS-1];
      end
   end

   // slab merge: touching intervals survive, strict compare rejects
   always_comb begin
      rej5_in  = (near_dist_ff[0] > far_dist_ff[1]) || (near_dist_ff[1] > far_dist_ff[0]);
      tmin5_in = (near_dist_ff[1] > near_dist_ff[0]) ? near_dist_ff[1] : near_dist_ff[0];
      tmax5_in = (far_dist_ff[1] < far_dist_ff[0]) ? far_dist_ff[1] : far_dist_ff[0];

      rej6_in  = rej5_ff || (tmin5_ff > far_z5_ff) || (near_z5_ff > tmax5_ff);
      tmin6_in = (near_z5_ff > tmin5_ff) ? near_z5_ff : tmin5_ff;
      tmax6_in = (far_z5_ff < tmax5_ff) ? far_z5_ff : tmax5_ff;

      if (rej6_ff) begin
         rsp_hit_in        = 1'b0;
         rsp_span_valid_in = 1'b0;
         rsp_entry_in      = '0;
         rsp_exit_in       = '0;
      end else begin
         rsp_hit_in        = (tmin6_ff < range_ff[rbst_pkg::PIPE_STAGES-1].range_high)
                          && (tmax6_ff > range_ff[rbst_pkg::PIPE_STAGES-1].range_low);
         rsp_span_valid_in = 1'b1;
         rsp_entry_in      = tmin6_ff;
         rsp_exit_in       = tmax6_ff;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      range_ff[0] <= '{range_low: req_range_low, range_high: req_range_high};
      for (int s = 1; s < rbst_pkg::PIPE_STAGES; s++) begin
         range_ff[s] <= range_ff[s-1];
      end
      for (int i = 0; i < rbst_pkg::NUM_AXES; i++) begin
         near_diff_ff[i] <= near_diff_in[i];
         far_diff_ff[i]  <= far_diff_in[i];
         rcp_ff[i]       <= rcp[i];

         near_mag_ff[i]  <= near_mag_in[i];
         far_mag_ff[i]   <= far_mag_in[i];
         rcp_mag_ff[i]   <= rcp_mag_in[i];
         near_neg_ff[i]  <= near_neg_in[i];
         far_neg_ff[i]   <= far_neg_in[i];

         near_prod_ff[i] <= rbst_pkg::prod_type'(near_mag_ff[i])
                          * rbst_pkg::prod_type'(rcp_mag_ff[i]);
         far_prod_ff[i]  <= rbst_pkg::prod_type'(far_mag_ff[i])
                          * rbst_pkg::prod_type'(rcp_mag_ff[i]);
         near_sgn_ff[i]  <= near_neg_ff[i];
         far_sgn_ff[i]   <= far_neg_ff[i];

         near_dist_ff[i] <= rbst_pkg::sat_scale(near_prod_ff[i], near_sgn_ff[i]);
         far_dist_ff[i]  <= rbst_pkg::sat_scale(far_prod_ff[i], far_sgn_ff[i]);
      end

      tmin5_ff   <= tmin5_in;
      tmax5_ff   <= tmax5_in;
      rej5_ff    <= rej5_in;
      near_z5_ff <= near_dist_ff[2];
      far_z5_ff  <= far_dist_ff[2];

      tmin6_ff <= tmin6_in;
      tmax6_ff <= tmax6_in;
      rej6_ff  <= rej6_in;

      rsp_hit_ff        <= rsp_hit_in;
      rsp_span_valid_ff <= rsp_span_valid_in;
      rsp_entry_ff      <= rsp_entry_in;
      rsp_exit_ff       <= rsp_exit_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_span_valid     = rsp_span_valid_ff;
   assign rsp_entry_distance = rsp_entry_ff;
   assign rsp_exit_distance  = rsp_exit_ff;

   `RBST_ASSERT_NEXT(a_last_stage_strobes, valid_ff[rbst_pkg::PIPE_STAGES-1], rsp_valid)
   `RBST_ASSERT_NEXT(a_reject_sticks, valid_ff[4] && rej5_ff, rej6_ff)
   `RBST_ASSERT_NEXT(a_zero_product_zero_dist, valid_ff[2] && near_prod_ff[0] == '0, near_dist_ff[0] == '0)
   `RBST_ASSERT_NOW(a_reject_clears_result, rsp_valid && !rsp_span_valid, !rsp_hit && rsp_entry_distance == '0 && rsp_exit_distance == '0)

endmodule

`default_nettype wire
